/* src/qpc_pkg.sv */
// ----------------------------------------------------------------------------
// qpc_pkg
// Types and constants shared by the quadrature position counter files.
// ----------------------------------------------------------------------------
package qpc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 41;
    localparam int DIST_W     = 32;
    localparam int COUNT_W    = 9;
    localparam int SUM_W      = DIST_W + 2;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_ZERO   = 2'd1,
        CMD_SET    = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef logic signed [2:0] t_move;

    localparam t_move MOVE_NEG2 = -3'sd2;
    localparam t_move MOVE_NEG1 = -3'sd1;
    localparam t_move MOVE_ZERO = 3'sd0;
    localparam t_move MOVE_POS1 = 3'sd1;
    localparam t_move MOVE_DBL  = 3'sd2;

    // indexed by {old AB phase, new AB phase}
    localparam t_move MOVE_TABLE [16] = '{
        MOVE_ZERO, MOVE_NEG1, MOVE_POS1, MOVE_DBL,
        MOVE_POS1, MOVE_ZERO, MOVE_DBL,  MOVE_NEG1,
        MOVE_NEG1, MOVE_DBL,  MOVE_ZERO, MOVE_POS1,
        MOVE_DBL,  MOVE_POS1, MOVE_NEG1, MOVE_ZERO
    };

    typedef struct packed {
        logic                     enable;
        logic [7:0]               debounce;
        logic signed [DIST_W-1:0] step;
    } t_setup;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic [1:0]               phase;
        logic [2:0]               prev;
        logic [COUNT_W-1:0]       count;
        logic                     neg;
    } t_chan_state;

    typedef struct packed {
        t_cmd                     command;
        logic [1:0]               channel;
        logic                     pin_a;
        logic                     pin_b;
        logic                     pin_z;
        logic signed [DIST_W-1:0] new_distance;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               channel_out;
        logic signed [DIST_W-1:0] distance_out;
        logic                     enabled_out;
    } t_out_item;

endpackage

/* src/qpc_in_if.sv */
// ----------------------------------------------------------------------------
// qpc_in_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface qpc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [1:0]        channel;
    logic              pin_a;
    logic              pin_b;
    logic              pin_z;
    logic signed [31:0] new_distance;

    modport source (
        output valid, command, channel, pin_a, pin_b, pin_z, new_distance,
        input  ready
    );

    modport sink (
        input  valid, command, channel, pin_a, pin_b, pin_z, new_distance,
        output ready
    );
endinterface

/* src/qpc_out_if.sv */
// ----------------------------------------------------------------------------
// qpc_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface qpc_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        channel_out;
    logic signed [31:0] distance_out;
    logic              enabled_out;

    modport source (
        output valid, channel_out, distance_out, enabled_out,
        input  ready
    );

    modport sink (
        input  valid, channel_out, distance_out, enabled_out,
        output ready
    );
endinterface

/* src/qpc_update.sv */
// ----------------------------------------------------------------------------
// qpc_update
// Next-state logic for one channel: debounce, phase decode, scaled
// saturating accumulate, index clear, zero/set/read commands.
// ----------------------------------------------------------------------------
module qpc_update (
    input  qpc_pkg::t_in_item    i_item,
    input  logic                 i_in_range,
    input  qpc_pkg::t_setup      i_setup,
    input  qpc_pkg::t_chan_state i_state,
    output qpc_pkg::t_chan_state o_state,
    output qpc_pkg::t_out_item   o_result
);
    import qpc_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

    logic [2:0]               phase;
    logic [COUNT_W-1:0]       limit;
    logic [COUNT_W-1:0]       count_n;
    logic                     step_ok;
    t_move                    move_raw;
    t_move                    move;
    logic signed [SUM_W-1:0]  step_x;
    logic signed [SUM_W-1:0]  prod;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] sat;
    t_chan_state              smp;

    always_comb begin
        phase   = {i_item.pin_z, i_item.pin_b, i_item.pin_a};
        limit   = {1'b0, i_setup.debounce};

        // saturating count of identical samples
        if (i_state.prev == phase) begin
            count_n = (i_state.count <= limit) ? COUNT_W'(i_state.count + 1'b1)
                                               : i_state.count;
        end else begin
            count_n = '0;
        end
        step_ok = (count_n == limit);

        move_raw = MOVE_TABLE[{i_state.phase, phase[1:0]}];
        move     = (move_raw == MOVE_DBL && i_state.neg) ? MOVE_NEG2 : move_raw;

        step_x = SUM_W'(i_setup.step);
        case (move)
            MOVE_POS1: prod = step_x;
            MOVE_NEG1: prod = -step_x;
            MOVE_DBL:  prod = step_x <<< 1;
            MOVE_NEG2: prod = -(step_x <<< 1);
            default:   prod = '0;
        endcase

        sum = SUM_W'(i_state.distance) + prod;
        if (sum > SAT_MAX) begin
            sat = DIST_W'(SAT_MAX);
        end else if (sum < SAT_MIN) begin
            sat = DIST_W'(SAT_MIN);
        end else begin
            sat = DIST_W'(sum);
        end

        smp       = i_state;
        smp.count = count_n;
        smp.prev  = phase;
        if (step_ok) begin
            smp.phase    = phase[1:0];
            smp.neg      = move[2];
            smp.distance = phase[2] ? '0 : sat;
        end

        o_state = i_state;
        case (i_item.command)
            CMD_SAMPLE: begin
                if (i_setup.enable) begin
                    o_state = smp;
                end
            end
            CMD_ZERO: o_state.distance = '0;
            CMD_SET:  o_state.distance = i_item.new_distance;
            CMD_READ: o_state = i_state;
            default:  o_state = i_state;
        endcase

        o_result.channel_out  = i_item.channel;
        o_result.distance_out = i_in_range ? o_state.distance : '0;
        o_result.enabled_out  = i_in_range & i_setup.enable;
    end

endmodule

/* src/quadrature_position_counter_unit.sv */
// ----------------------------------------------------------------------------
// quadrature_position_counter_unit
// Multi-channel quadrature decoder with index input and per-channel setup.
//
//   port      dir   handshake     word
//   i_in      in    valid/ready   command, channel, pins, new_distance
//   o_out     out   valid/ready   channel_out, distance_out, enabled_out
//   i_cfg_*   in    write enable  channel setup, index = channel
//
// one command per clock while the result register is not stalled
// command register feeds the update logic, whose result lands in the result
// register in the same clock as the channel state write
// a stalled result register holds the command register; i_in.ready drops
// only while both are full
// synchronous active-low reset clears setup, channel state and valid flags
// ----------------------------------------------------------------------------
module quadrature_position_counter_unit #(
    parameter int CHANNELS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    qpc_in_if.sink                        i_in,
    qpc_out_if.source                     o_out
);
    import qpc_pkg::*;

    localparam int              CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [2:0]      CH_LIMIT = 3'(CHANNELS);

    t_setup      r_setup [CHANNELS];
    t_chan_state r_state [CHANNELS];
    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        advance;
    logic        in_range;
    logic [CH_W-1:0] ch;
    t_setup      cur_setup;
    t_chan_state cur_state;
    t_chan_state n_state;
    t_out_item   n_out;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_range    = ({1'b0, r_in.channel} < CH_LIMIT);
    assign ch          = r_in.channel[CH_W-1:0];
    assign cur_setup   = in_range ? r_setup[ch] : '0;
    assign cur_state   = in_range ? r_state[ch] : '0;

    qpc_update u_update (
        .i_item     (r_in),
        .i_in_range (in_range),
        .i_setup    (cur_setup),
        .i_state    (cur_state),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_setup[i] <= '0;
                r_state[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (i_cfg_idx == CFG_IDX_W'(i)) begin
                        r_setup[i] <= i_cfg_data;
                    end
                end
            end

            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                if (in_range) begin
                    r_state[ch] <= n_state;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.command      <= t_cmd'(i_in.command);
            r_in.channel      <= i_in.channel;
            r_in.pin_a        <= i_in.pin_a;
            r_in.pin_b        <= i_in.pin_b;
            r_in.pin_z        <= i_in.pin_z;
            r_in.new_distance <= i_in.new_distance;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.channel_out  = r_out.channel_out;
    assign o_out.distance_out = r_out.distance_out;
    assign o_out.enabled_out  = r_out.enabled_out;

endmodule
